[rtl/dsli_pkg.sv]
// Shared constants and types for the descending sorted list insert block.
package dsli_pkg;

    // Default number of list slots
    localparam int unsigned DefCapacity = 64;

    // Result field widths
    localparam int unsigned ValueW = 32;
    localparam int unsigned SlotW  = 6;
    localparam int unsigned CountW = 7;

    // Packed stream widths
    localparam int unsigned InDataW  = 32;
    localparam int unsigned OutDataW = 80;

    // Link from one cell to the next one down the row
    typedef struct packed {
        logic                     gt;    // new value is above this cell's entry
        logic signed [ValueW-1:0] data;  // entry held by this cell
    } dsli_link_t;

endpackage

[rtl/dsli_cell.sv]
// One slot of the sorted row: compares, holds and shifts its entry.
module dsli_cell import dsli_pkg::*; #(
    parameter int unsigned CNT_W = 7,
    parameter int unsigned IDX   = 0
) (
    input  logic                     aclk,
    input  logic                     load_en,
    input  logic signed [ValueW-1:0] new_value,
    input  logic [CNT_W-1:0]         count,
    input  dsli_link_t               link_i,
    output dsli_link_t               link_o,
    output logic                     first_o
);

    localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

    logic signed [ValueW-1:0] entry_reg;
    logic signed [ValueW-1:0] entry_next;
    logic                     occupied;
    logic                     gt;
    logic                     at_end;

    // Compare against the held entry; only occupied slots count
    always_comb begin
        occupied = (MyIdx < count);
        at_end   = (MyIdx == count);
        gt       = occupied && (new_value > entry_reg);
        first_o  = (gt || at_end) && !link_i.gt;
    end

    // Shift from the upper neighbor, take the new value, or hold
    always_comb begin
        entry_next = entry_reg;
        if (link_i.gt) begin
            entry_next = link_i.data;
        end else if (gt || at_end) begin
            entry_next = new_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            entry_reg <= entry_next;
        end
    end

    assign link_o.gt   = gt;
    assign link_o.data = entry_reg;

endmodule

[rtl/descending_sorted_list_insert.sv]
// Top level: row of sorted cells, list statistics and the result register.
//
//  channel | dir | fields
//  s_      | in  | tdata: new_value
//  m_      | out | tdata: insert_slot, count_after, largest_now, smallest_now;
//          |     | tuser: dropped
//
// One item per cycle while s_tready is high: every cell compares and shifts
// in parallel, so the 32-bit compare plus the slot encoder over all cells
// set the cycle. A result appears in the cycle after its item is taken and
// waits in the output register; input is still taken while m_tready is high.
// Reset empties the list (count, largest and smallest to zero).
module descending_sorted_list_insert import dsli_pkg::*; #(
    parameter int unsigned CAPACITY = DefCapacity
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [InDataW-1:0]   s_tdata,   // [31:0] new_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutDataW-1:0]  m_tdata,   // [5:0] insert_slot, [12:6] count_after,
                                            // [44:13] largest_now,
                                            // [76:45] smallest_now, [79:77] zero
    output logic                 m_tuser    // [0] dropped
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

    logic                     accept;
    logic                     full;
    logic                     load_en;
    logic signed [ValueW-1:0] new_value;

    logic [CNT_W-1:0]         count_reg,    count_next;
    logic signed [ValueW-1:0] largest_reg,  largest_next;
    logic signed [ValueW-1:0] smallest_reg, smallest_next;

    logic                     m_valid_reg;
    logic [OutDataW-1:0]      m_data_reg,   m_data_next;
    logic                     m_drop_reg;

    dsli_link_t               links [CAPACITY+1];
    logic [CAPACITY-1:0]      first_vec;
    logic [IDX_W-1:0]         slot;
    logic [IDX_W+SlotW-1:0]   slot_ext;
    logic [CNT_W+CountW-1:0]  count_ext;

    assign new_value = s_tdata[ValueW-1:0];
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CapCount);
    assign load_en   = accept && !full;

    // Nothing sits above slot 0
    assign links[0] = '0;

    // Row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dsli_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .aclk      (aclk),
            .load_en   (load_en),
            .new_value (new_value),
            .count     (count_reg),
            .link_i    (links[g]),
            .link_o    (links[g+1]),
            .first_o   (first_vec[g])
        );
    end

    // Encode the single cell that takes the new value
    always_comb begin
        slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_vec[i]) begin
                slot = slot | IDX_W'(i);
            end
        end
    end

    // Advance count and extremes
    always_comb begin
        count_next    = count_reg;
        largest_next  = largest_reg;
        smallest_next = smallest_reg;
        if (load_en) begin
            count_next = count_reg + CNT_W'(1);
            if (count_reg == '0) begin
                largest_next  = new_value;
                smallest_next = new_value;
            end else begin
                if (new_value > largest_reg) begin
                    largest_next = new_value;
                end
                if (new_value < smallest_reg) begin
                    smallest_next = new_value;
                end
            end
        end
    end

    // Build the result item
    always_comb begin
        slot_ext  = {{SlotW{1'b0}}, (full ? {IDX_W{1'b0}} : slot)};
        count_ext = {{CountW{1'b0}}, count_next};
        m_data_next = '0;
        m_data_next[SlotW-1:0]                   = slot_ext[SlotW-1:0];
        m_data_next[SlotW+CountW-1:SlotW]        = count_ext[CountW-1:0];
        m_data_next[SlotW+CountW+ValueW-1:SlotW+CountW] = largest_next;
        m_data_next[SlotW+CountW+2*ValueW-1:SlotW+CountW+ValueW] = smallest_next;
    end

    // Hold list statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            largest_reg  <= '0;
            smallest_reg <= '0;
        end else begin
            count_reg    <= count_next;
            largest_reg  <= largest_next;
            smallest_reg <= smallest_next;
        end
    end

    // Output register: load on accept, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            m_drop_reg <= full;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_drop_reg;

endmodule

[dv/descending_sorted_list_insert_tb.sv]
// Testbench for descending_sorted_list_insert: stream stimulus, list predictor and result checks.
module descending_sorted_list_insert_tb;
    import dsli_pkg::*;

    localparam int unsigned TotalItems = 2000;
    localparam int unsigned CalmItems  = 200;
    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned LongHold   = 60;

    // One expected result, in the order of its fields on the result stream
    typedef struct packed {
        logic [SlotW-1:0]         slot;
        logic [CountW-1:0]        count;
        logic signed [ValueW-1:0] largest;
        logic signed [ValueW-1:0] smallest;
        logic                     dropped;
    } list_result_t;

    // Sorted list predictor plus the queue of results still owed by the block
    class insert_scoreboard;
        logic signed [ValueW-1:0] entries [DefCapacity];
        int unsigned              stored = 0;
        logic signed [ValueW-1:0] largest = '0;
        logic signed [ValueW-1:0] smallest = '0;
        list_result_t             owed_q [$];
        int unsigned              mismatches = 0;

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        // Insert after all entries that are not smaller, or drop when full
        function void note_insert(logic signed [ValueW-1:0] v);
            list_result_t r;
            int unsigned  pos;
            r = '0;
            if (stored >= DefCapacity) begin
                r.dropped = 1'b1;
            end else begin
                pos = stored;
                for (int i = 0; i < stored; i++) begin
                    if (v > entries[i]) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = stored; i > pos; i--) entries[i] = entries[i-1];
                entries[pos] = v;
                if (stored == 0) begin
                    largest  = v;
                    smallest = v;
                end else begin
                    if (v > largest) largest = v;
                    if (v < smallest) smallest = v;
                end
                stored++;
                r.slot = pos[SlotW-1:0];
            end
            r.count    = stored[CountW-1:0];
            r.largest  = largest;
            r.smallest = smallest;
            owed_q.push_back(r);
        endfunction

        task compare_field(string name, longint got, longint want);
            if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        // Unpack one result and compare it against the oldest owed one
        task check_result(logic [OutDataW-1:0] data, logic user);
            list_result_t e;
            if (owed_q.size() == 0) begin
                report("result with no item waiting for one");
                return;
            end
            e = owed_q.pop_front();
            compare_field("insert_slot", data[5:0], e.slot);
            compare_field("count_after", data[12:6], e.count);
            compare_field("largest_now", $signed(data[44:13]), e.largest);
            compare_field("smallest_now", $signed(data[76:45]), e.smallest);
            compare_field("pad", data[79:77], 0);
            compare_field("dropped", user, e.dropped);
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;

    insert_scoreboard sb = new();
    bit               tx_idle_en;
    bit               rx_idle_en;
    int unsigned      hold_reqs;
    int unsigned      cycles;

    descending_sorted_list_insert u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // Check results before noting a new item: a result always belongs to an older item
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.note_insert(s_tdata);
        end
    end

    // Receiver: random stall bursts, plus long hold-offs on request
    initial begin
        int unsigned holds_done;
        int unsigned stall_left;
        holds_done = 0;
        stall_left = 0;
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_reqs != holds_done) begin
                m_tready <= 1'b0;
                repeat (LongHold) @(negedge aclk);
                holds_done++;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Drop valid for a short burst now and then
    task automatic tx_gap();
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    // Offer one item and hold it until taken; returns on a falling edge
    task automatic send_value(logic [InDataW-1:0] v);
        tx_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mix of full-range values, small values that tie, extremes and repeats of stored ones
    function automatic logic [InDataW-1:0] pick_value();
        logic [InDataW-1:0] v;
        case ($urandom_range(0, 9))
            5, 6: v = $urandom_range(0, 16) - 8;
            7: v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            8: v = (sb.stored > 0) ? sb.entries[$urandom_range(0, sb.stored - 1)] : $urandom;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        logic [InDataW-1:0] directed [$];
        int unsigned        sent;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        aresetn    = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        hold_reqs  = 0;
        cycles     = 0;
        directed = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0005, 32'hffff_fffb,
                     32'h0000_0005, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h8000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h5555_5555,
                     32'haaaa_aaaa, 32'h7fff_fffe, 32'h8000_0001, 32'h0000_0000};
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty list, ties in the middle and at both ends, extremes
        foreach (directed[i]) send_value(directed[i]);
        sent = directed.size();

        // Hold the receiver off while items keep coming, so the block backs up
        hold_reqs++;
        repeat (24) begin
            send_value(pick_value());
            sent++;
        end

        // Pause the sender until everything owed has come back
        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(negedge aclk);

        // Random items: fill the list, then run it full; calm at the end
        while (sent < TotalItems) begin
            if (sent == TotalItems - CalmItems) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            send_value(pick_value());
            sent++;
        end
        s_tvalid <= 1'b0;

        // Drain, then keep watching for stray results before the verdict
        while (sb.owed_q.size() != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
